/* src/wde_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wde_pkg
// Shared types and constants for the wrapped distance and equality block.
// ----------------------------------------------------------------------------
package wde_pkg;

  localparam int DIMS       = 6;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = 33;
  localparam int RANGE_W    = 31;
  localparam int TOL_W      = 16;
  localparam int MAG_W      = 32;
  localparam int SQ_W       = 64;
  localparam int SUM_W      = 67;
  localparam int DIST_W     = 34;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // remainder unit: one quotient bit per stage
  localparam int REM_STAGES = 32;
  // square root: one result bit per stage
  localparam int ROOT_STAGES = DIST_W;

  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(411775);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRAP_MASK = 4'd0,
    REG_RANGE0    = 4'd1,
    REG_RANGE1    = 4'd2,
    REG_RANGE2    = 4'd3,
    REG_RANGE3    = 4'd4,
    REG_RANGE4    = 4'd5,
    REG_RANGE5    = 4'd6,
    REG_TOLERANCE = 4'd7
  } reg_idx_t;

endpackage

`default_nettype wire

/* src/wde_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wde_lane
// One dimension: difference, magnitude, pipelined truncated remainder by the
// period, fold into half a period, tolerance test and square.
// ----------------------------------------------------------------------------
module wde_lane
  import wde_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [COORD_W-1:0]  coord_a,
  input  wire logic signed [COORD_W-1:0]  coord_b,
  input  wire logic                       wrap,
  input  wire logic [RANGE_W-1:0]         period,
  input  wire logic [TOL_W-1:0]           tolerance,
  output logic [SQ_W-1:0]                 square,
  output logic                            in_tol
);

  // per stage state of the restoring remainder
  logic [MAG_W:0]       rem   [REM_STAGES+1];
  logic [MAG_W:0]       quo   [REM_STAGES+1];
  logic [RANGE_W-1:0]   per   [REM_STAGES+1];
  logic                 neg   [REM_STAGES+1];
  logic                 wr    [REM_STAGES+1];

  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W:0]           dmag;

  // difference and its magnitude (up to 2^32)
  assign diff = DIFF_W'(coord_a) - DIFF_W'(coord_b);
  assign dmag = diff[DIFF_W-1] ? (MAG_W+1)'(-diff) : (MAG_W+1)'(diff);

  assign rem[0] = '0;
  assign quo[0] = dmag;
  assign per[0] = period;
  assign neg[0] = diff[DIFF_W-1];
  assign wr[0]  = wrap && (period != '0);

  // long division of the magnitude, one dividend bit per stage, two in the first
  for (genvar s = 0; s < REM_STAGES; s++) begin : g_rem
    logic [MAG_W+1:0] shifted;
    logic [MAG_W+1:0] trial;
    // the magnitude has 33 bits; stage 0 takes the top two
    if (s == 0) begin : g_first
      assign shifted = (MAG_W+2)'(quo[s][MAG_W:MAG_W-1]);
    end else begin : g_rest
      assign shifted = {rem[s], quo[s][MAG_W-1-s]};
    end
    assign trial = shifted - (MAG_W+2)'(per[s]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= trial[MAG_W+1] ? shifted[MAG_W:0] : trial[MAG_W:0];
        quo[s+1] <= quo[s];
        per[s+1] <= per[s];
        neg[s+1] <= neg[s];
        wr[s+1]  <= wr[s];
      end
    end
  end

  // fold into plus or minus half the period
  logic [MAG_W:0]     r_mag;
  logic [MAG_W+1:0]   two_r;
  logic [MAG_W:0]     folded;
  logic [MAG_W:0]     fmag;
  logic [MAG_W:0]     pd;

  always_comb begin
    pd     = (MAG_W+1)'(per[REM_STAGES]);
    r_mag  = rem[REM_STAGES];
    two_r  = {r_mag, 1'b0};
    folded = r_mag;
    if (two_r > (MAG_W+2)'(pd)) begin
      folded = pd - r_mag;
    end
    fmag = wr[REM_STAGES] ? folded : quo[REM_STAGES];
  end

  // fmag is below 2^32 on every path
  logic [MAG_W-1:0] mag_q;
  logic             within_q;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_q    <= fmag[MAG_W-1:0];
      within_q <= (fmag <= (MAG_W+1)'(tolerance));
    end
  end

  // square
  always_ff @(posedge clk) begin
    if (en) begin
      square <= mag_q * mag_q;
      in_tol <= within_q;
    end
  end

endmodule

`default_nettype wire

/* src/wde_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wde_sqrt
// Merging stage: sums lane squares, ANDs the lane tolerance flags and takes a
// pipelined floored integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module wde_sqrt
  import wde_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [SQ_W-1:0]  squares [DIMS],
  input  wire logic [DIMS-1:0]  in_tol,
  output logic [DIST_W-1:0]     root,
  output logic                  equal
);

  // adder tree: pairs, then total
  logic [SQ_W:0]    pair  [DIMS/2];
  logic             eq1;
  logic [SUM_W-1:0] total;
  logic             eq2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < DIMS/2; p++) begin
        pair[p] <= (SQ_W+1)'(squares[2*p]) + (SQ_W+1)'(squares[2*p+1]);
      end
      eq1 <= &in_tol;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total <= SUM_W'(pair[0]) + SUM_W'(pair[1]) + SUM_W'(pair[2]);
      eq2   <= eq1;
    end
  end

  // restoring digit recurrence on remainder and partial root
  localparam int REM_W = DIST_W + 2;
  logic [2*DIST_W-1:0] val [ROOT_STAGES+1];
  logic [REM_W-1:0]    rm  [ROOT_STAGES+1];
  logic [DIST_W-1:0]   rt  [ROOT_STAGES+1];
  logic                eqp [ROOT_STAGES+1];

  assign val[0] = (2*DIST_W)'(total);
  assign rm[0]  = '0;
  assign rt[0]  = '0;
  assign eqp[0] = eq2;

  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_root
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    assign cur   = {rm[s], val[s][2*DIST_W-1 -: 2]};
    assign trial = cur - (REM_W+2)'({rt[s], 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        val[s+1] <= {val[s][2*DIST_W-3:0], 2'b00};
        eqp[s+1] <= eqp[s];
        if (!trial[REM_W+1]) begin
          rm[s+1] <= trial[REM_W-1:0];
          rt[s+1] <= {rt[s][DIST_W-2:0], 1'b1};
        end else begin
          rm[s+1] <= cur[REM_W-1:0];
          rt[s+1] <= {rt[s][DIST_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root  = rt[ROOT_STAGES];
  assign equal = eqp[ROOT_STAGES];

endmodule

`default_nettype wire

/* src/wrapped_distance_and_equality.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wrapped_distance_and_equality
// Toroidal Euclidean distance of two six-dimensional Q16.16 points, with wrap
// enabled per dimension, and an equality test of every dimension against one
// shared tolerance. Pipeline: 32 remainder stages, fold, square, two adder
// stages, 34 square root stages and the output register.
// Throughput: one request per cycle; the whole pipeline stalls only when the
// output register is full and not taken.
// Reset: clears valid bits and restores register defaults.
// ----------------------------------------------------------------------------
module wrapped_distance_and_equality
  import wde_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] first_coord_0,
  input  wire logic signed [COORD_W-1:0] first_coord_1,
  input  wire logic signed [COORD_W-1:0] first_coord_2,
  input  wire logic signed [COORD_W-1:0] first_coord_3,
  input  wire logic signed [COORD_W-1:0] first_coord_4,
  input  wire logic signed [COORD_W-1:0] first_coord_5,
  input  wire logic signed [COORD_W-1:0] second_coord_0,
  input  wire logic signed [COORD_W-1:0] second_coord_1,
  input  wire logic signed [COORD_W-1:0] second_coord_2,
  input  wire logic signed [COORD_W-1:0] second_coord_3,
  input  wire logic signed [COORD_W-1:0] second_coord_4,
  input  wire logic signed [COORD_W-1:0] second_coord_5,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [DIST_W-1:0]              distance,
  output logic                           points_equal,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int LAT = REM_STAGES + 2 + 2 + ROOT_STAGES;

  // configuration registers
  logic [DIMS-1:0]    wrap_mask;
  logic [RANGE_W-1:0] range_dim [DIMS];
  logic [TOL_W-1:0]   equal_tolerance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_mask       <= '0;
      equal_tolerance <= '0;
      for (int d = 0; d < DIMS; d++) begin
        range_dim[d] <= RANGE_RESET;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WRAP_MASK: wrap_mask <= cfg_data[DIMS-1:0];
        REG_RANGE0:    range_dim[0] <= cfg_data[RANGE_W-1:0];
        REG_RANGE1:    range_dim[1] <= cfg_data[RANGE_W-1:0];
        REG_RANGE2:    range_dim[2] <= cfg_data[RANGE_W-1:0];
        REG_RANGE3:    range_dim[3] <= cfg_data[RANGE_W-1:0];
        REG_RANGE4:    range_dim[4] <= cfg_data[RANGE_W-1:0];
        REG_RANGE5:    range_dim[5] <= cfg_data[RANGE_W-1:0];
        REG_TOLERANCE: equal_tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output slot is free or being taken
  logic [LAT-1:0] vld;
  logic stage_en;
  assign stage_en = !out_valid || out_ready;
  assign in_ready = stage_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (stage_en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [COORD_W-1:0] ca [DIMS];
  logic signed [COORD_W-1:0] cb [DIMS];
  assign ca = '{first_coord_0, first_coord_1, first_coord_2,
                first_coord_3, first_coord_4, first_coord_5};
  assign cb = '{second_coord_0, second_coord_1, second_coord_2,
                second_coord_3, second_coord_4, second_coord_5};

  logic [SQ_W-1:0] sq [DIMS];
  logic [DIMS-1:0] in_tol;

  // one lane per dimension
  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    wde_lane u_lane (
      .clk       (clk),
      .en        (stage_en),
      .coord_a   (ca[d]),
      .coord_b   (cb[d]),
      .wrap      (wrap_mask[d]),
      .period    (range_dim[d]),
      .tolerance (equal_tolerance),
      .square    (sq[d]),
      .in_tol    (in_tol[d])
    );
  end

  logic [DIST_W-1:0] root;
  logic              eq;

  wde_sqrt u_sqrt (
    .clk     (clk),
    .en      (stage_en),
    .squares (sq),
    .in_tol  (in_tol),
    .root    (root),
    .equal   (eq)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_en) begin
      out_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      distance     <= root;
      points_equal <= eq;
    end
  end

endmodule

`default_nettype wire
